// File: hw/rtl/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types and constants of the graph independent set / coloring engine.
// ----------------------------------------------------------------------------
package gmc_pkg;

    // Field and register widths
    localparam int KIND_W    = 3;
    localparam int ADDR_W    = 13;
    localparam int DATA_W    = 14;
    localparam int ANS_W     = 11;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int NUMV_W    = 11;
    localparam int PTR_W     = 14;
    localparam int NB_W      = 11;
    localparam int MARK_W    = 3;
    localparam int PRIO_W    = 32;

    localparam logic [CFG_W-1:0] SEED_RESET = 32'd1779033703;
    localparam logic [NUMV_W-1:0] NUMV_RESET = 11'd1024;

    // Input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ROW_PTR  = 3'd0,
        KIND_NEIGHBOR = 3'd1,
        KIND_AVAIL    = 3'd2,
        KIND_RUN      = 3'd3,
        KIND_READ     = 3'd4
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_VERTICES  = 2'd0,
        CFG_INDEX_BASE    = 2'd1,
        CFG_RUN_MODE      = 2'd2,
        CFG_SEED_FRACTION = 2'd3
    } cfg_index_t;

    // Per-vertex mark codes kept in the mark memory
    typedef enum logic [MARK_W-1:0] {
        MK_NONE   = 3'd0,
        MK_AVAIL  = 3'd1,
        MK_NOW    = 3'd2,
        MK_IN     = 3'd3,
        MK_CONN   = 3'd4,
        MK_MEMBER = 3'd5,
        MK_DONE   = 3'd6
    } mark_t;

    // Sweep phase of a round
    typedef enum logic {
        PH_SEL = 1'b0,
        PH_REM = 1'b1
    } phase_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RUN_START,
        ST_INIT,
        ST_VA,
        ST_VB,
        ST_VC,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_FA,
        ST_FB,
        ST_CLEAN,
        ST_REPORT
    } state_t;

endpackage

// File: hw/rtl/gmc_ram.sv
// ----------------------------------------------------------------------------
// gmc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/graph_mis_coloring.sv
// ----------------------------------------------------------------------------
// graph_mis_coloring
// Maximal independent set and graph coloring engine over a sparse pattern.
//
// Input channel (in_valid / in_stall, fields kind, addr, data) carries one
// transaction per item: row pointer, neighbor index and availability writes
// give no result. A read transaction gives one result (from_run = 0),
// loaded into the output register from the read state once it is free.
// A run transaction sweeps the mark memory vertex by vertex and gives one
// completion result (from_run = 1). A run holds selection and removal
// sweeps of every round, which walk the stored neighbors of each vertex,
// plus a closing sweep of each pass. One item is in work at a time.
// Config port (cfg_we, cfg_index, cfg_data) writes a register. The user must
// see that it is only written while the block is idle; the block does not
// enforce it. After reset the block clears the mark memory, one entry a
// cycle, and holds in_stall high meanwhile.
// Output channel (out_valid / out_stall): a result stays in the output
// register until taken; the sequencer waits for the register to free.
// ----------------------------------------------------------------------------
module graph_mis_coloring #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_ENTRIES  = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gmc_pkg::KIND_W-1:0]    kind,
    input  logic [gmc_pkg::ADDR_W-1:0]    addr,
    input  logic [gmc_pkg::DATA_W-1:0]    data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gmc_pkg::ANS_W-1:0]     answer,
    output logic                          from_run
);

    import gmc_pkg::*;

    localparam int VAW  = $clog2(MAX_VERTICES);
    localparam int RPAW = $clog2(MAX_VERTICES + 1);
    localparam int EAW  = $clog2(MAX_ENTRIES);
    localparam int EPW  = $clog2(MAX_ENTRIES + 1);
    localparam int PW   = (EPW > PTR_W + 1) ? EPW : PTR_W + 1;

    // Clamp a stored row pointer to the entry range
    function automatic logic [PW-1:0] clamp_ptr(input logic [PTR_W-1:0] ptr,
                                                input logic base);
        logic [PTR_W:0] p;
        logic [PW-1:0]  pw;
        p = (ptr == '0 && base) ? '0 : ({1'b0, ptr} - {{PTR_W{1'b0}}, base});
        pw = PW'(p);
        if (pw > PW'(MAX_ENTRIES))
        begin
            pw = PW'(MAX_ENTRIES);
        end
        return pw;
    endfunction

    // Configuration registers
    logic [NUMV_W-1:0] num_vertices_reg;
    logic              index_base_reg;
    logic              run_mode_reg;
    logic [CFG_W-1:0]  seed_reg;

    // Control registers
    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [VAW-1:0]    clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic              fwd_hit_reg, fwd_hit_next;

    // Working registers
    logic [NUMV_W-1:0] v_reg, v_next;
    logic [PW-1:0]     e_reg, e_next;
    logic [PW-1:0]     end_reg, end_next;
    logic [NB_W-1:0]   nb_reg, nb_next;
    logic [PRIO_W-1:0] prio_v_reg, prio_v_next;
    logic [PRIO_W-1:0] prio_nb_reg, prio_nb_next;
    logic              any_avail_reg, any_avail_next;
    logic              any_unc_reg, any_unc_next;
    logic [ANS_W-1:0]  pass_reg, pass_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ANS_W-1:0]  answer_reg, answer_next;
    logic              from_run_reg, from_run_next;
    logic [MARK_W-1:0] fwd_data_reg, fwd_data_next;

    // Memory ports
    logic              mk_we;
    logic [VAW-1:0]    mk_waddr, mk_raddr;
    logic [MARK_W-1:0] mk_wdata, mk_rdata;
    logic              rp_we;
    logic [RPAW-1:0]   rp_waddr, rp_raddr;
    logic [PTR_W-1:0]  rp_rdata;
    logic              nbr_we;
    logic [EAW-1:0]    nbr_waddr;
    logic [NB_W-1:0]   nbr_rdata;
    logic              col_we;
    logic [VAW-1:0]    col_waddr, col_raddr;
    logic [ANS_W-1:0]  col_rdata;

    // Helper signals
    logic [NUMV_W-1:0] n_eff;
    logic [NUMV_W:0]   vp1;
    logic              last_v;
    logic [MARK_W-1:0] mark_rd;
    logic [PW-1:0]     rp_clamped;
    logic [NB_W:0]     nb_raw;
    logic              nb_ok;
    logic              blocker;
    logic              out_free;
    logic              in_accept;
    logic              vertex_skip;
    logic              vertex_done;
    logic              entries_done;
    logic              this_unc;
    logic [NUMV_W:0]   mul_op;
    logic [PRIO_W-1:0] seed_odd;
    logic [PRIO_W-1:0] prio_prod;
    logic              rd_in_range;

    // Memories
    gmc_ram #(.WIDTH(MARK_W), .DEPTH(MAX_VERTICES)) u_mark_ram (
        .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(mk_raddr), .rdata(mk_rdata)
    );

    gmc_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VERTICES + 1)) u_rowptr_ram (
        .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(data),
        .raddr(rp_raddr), .rdata(rp_rdata)
    );

    gmc_ram #(.WIDTH(NB_W), .DEPTH(MAX_ENTRIES)) u_nbr_ram (
        .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(data[NB_W-1:0]),
        .raddr(EAW'(e_reg)), .rdata(nbr_rdata)
    );

    gmc_ram #(.WIDTH(ANS_W), .DEPTH(MAX_VERTICES)) u_colour_ram (
        .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(pass_reg),
        .raddr(col_raddr), .rdata(col_rdata)
    );

    // Decode shared conditions
    always_comb
    begin
        n_eff = (32'(num_vertices_reg) > 32'(MAX_VERTICES))
              ? NUMV_W'(MAX_VERTICES) : num_vertices_reg;
        vp1 = {1'b0, v_reg} + (NUMV_W + 1)'(1);
        last_v = (vp1 == {1'b0, n_eff});
        mark_rd = fwd_hit_reg ? fwd_data_reg : mk_rdata;
        rp_clamped = clamp_ptr(rp_rdata, index_base_reg);
        nb_raw = {1'b0, nbr_rdata} - {{NB_W{1'b0}}, index_base_reg};
        nb_ok = !(nbr_rdata == '0 && index_base_reg)
              && (nb_raw < {1'b0, n_eff})
              && (nb_raw[NB_W-1:0] != v_reg);
        blocker = (mark_rd == MK_AVAIL || mark_rd == MK_NOW)
                && (prio_nb_reg <= prio_v_reg);
        out_free = !out_valid_reg || !out_stall;
        in_stall = (state_reg != ST_IDLE);
        in_accept = in_valid && !in_stall;
        vertex_skip = (phase_reg == PH_SEL) ? (mark_rd != MK_AVAIL)
                                            : (mark_rd != MK_NOW);
        entries_done = (e_reg >= end_reg);
        vertex_done = (state_reg == ST_VB && vertex_skip)
                    || (state_reg == ST_E0 && entries_done)
                    || (state_reg == ST_E3 && phase_reg == PH_SEL && blocker);
        this_unc = (mark_rd != MK_IN) && (mark_rd != MK_DONE);
        rd_in_range = 32'(addr_reg) < 32'(MAX_VERTICES);
        seed_odd = seed_reg | PRIO_W'(1);
        mul_op = (state_reg == ST_E2) ? ({1'b0, nb_reg} + (NUMV_W + 1)'(1)) : vp1;
        prio_prod = seed_odd * PRIO_W'(mul_op);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == VAW'(MAX_VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && kind == KIND_READ)
                begin
                    state_next = ST_READ;
                end
                else if (in_accept && kind == KIND_RUN)
                begin
                    state_next = ST_RUN_START;
                end
            end
            ST_READ, ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN_START:
            begin
                if (n_eff == '0)
                begin
                    state_next = ST_REPORT;
                end
                else if (!run_mode_reg)
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    state_next = ST_VA;
                end
            end
            ST_INIT:
            begin
                if (last_v)
                begin
                    state_next = ST_VA;
                end
            end
            ST_VA:
            begin
                state_next = ST_VB;
            end
            ST_VB:
            begin
                state_next = ST_VC;
            end
            ST_VC:
            begin
                state_next = ST_E0;
            end
            ST_E0:
            begin
                state_next = ST_E1;
            end
            ST_E1:
            begin
                state_next = nb_ok ? ST_E2 : ST_E0;
            end
            ST_E2:
            begin
                state_next = ST_E3;
            end
            ST_E3:
            begin
                state_next = ST_E0;
            end
            ST_FA:
            begin
                state_next = ST_FB;
            end
            ST_FB:
            begin
                if (last_v)
                begin
                    if (run_mode_reg)
                    begin
                        state_next = ST_REPORT;
                    end
                    else if (any_unc_reg || this_unc)
                    begin
                        state_next = ST_VA;
                    end
                    else
                    begin
                        state_next = ST_CLEAN;
                    end
                end
                else
                begin
                    state_next = ST_FA;
                end
            end
            ST_CLEAN:
            begin
                if (last_v)
                begin
                    state_next = ST_REPORT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Leave the current vertex
        if (vertex_done)
        begin
            if (last_v && phase_reg == PH_SEL && !any_avail_reg)
            begin
                state_next = ST_FA;
            end
            else
            begin
                state_next = ST_VA;
            end
        end
    end

    // Datapath and memory control
    always_comb
    begin
        phase_next     = phase_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        v_next         = v_reg;
        e_next         = e_reg;
        end_next       = end_reg;
        nb_next        = nb_reg;
        prio_v_next    = prio_v_reg;
        prio_nb_next   = prio_nb_reg;
        any_avail_next = any_avail_reg;
        any_unc_next   = any_unc_reg;
        pass_next      = pass_reg;
        addr_next      = addr_reg;
        answer_next    = answer_reg;
        from_run_next  = from_run_reg;

        mk_we     = 1'b0;
        mk_waddr  = VAW'(v_reg);
        mk_wdata  = MK_NONE;
        mk_raddr  = VAW'(v_reg);
        rp_we     = 1'b0;
        rp_waddr  = RPAW'(addr);
        rp_raddr  = RPAW'(v_reg);
        nbr_we    = 1'b0;
        nbr_waddr = EAW'(addr);
        col_we    = 1'b0;
        col_waddr = VAW'(v_reg);
        col_raddr = VAW'(addr_reg);

        // Drop a result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mk_we    = 1'b1;
                mk_waddr = clr_reg;
                clr_next = clr_reg + VAW'(1);
            end
            ST_IDLE:
            begin
                mk_raddr  = VAW'(addr);
                col_raddr = VAW'(addr);
                addr_next = addr;
                if (in_accept)
                begin
                    unique case (kind)
                        KIND_ROW_PTR:
                        begin
                            rp_we = 32'(addr) < 32'(MAX_VERTICES + 1);
                        end
                        KIND_NEIGHBOR:
                        begin
                            nbr_we = 32'(addr) < 32'(MAX_ENTRIES);
                        end
                        KIND_AVAIL:
                        begin
                            mk_we    = 32'(addr) < 32'(MAX_VERTICES);
                            mk_waddr = VAW'(addr);
                            mk_wdata = (data != '0) ? MK_AVAIL : MK_NONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                mk_raddr = VAW'(addr_reg);
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    from_run_next  = 1'b0;
                    if (!rd_in_range)
                    begin
                        answer_next = '0;
                    end
                    else if (!run_mode_reg)
                    begin
                        answer_next = col_rdata;
                    end
                    else
                    begin
                        answer_next = ANS_W'(mark_rd == MK_MEMBER);
                    end
                end
            end
            ST_RUN_START:
            begin
                v_next         = '0;
                pass_next      = '0;
                phase_next     = PH_SEL;
                any_avail_next = 1'b0;
            end
            ST_INIT:
            begin
                mk_we    = 1'b1;
                mk_wdata = MK_AVAIL;
                v_next   = last_v ? '0 : vp1[NUMV_W-1:0];
            end
            ST_VA:
            begin
                rp_raddr = RPAW'(v_reg);
            end
            ST_VB:
            begin
                rp_raddr    = RPAW'(vp1);
                e_next      = rp_clamped;
                prio_v_next = prio_prod;
                if (phase_reg == PH_SEL && mark_rd == MK_AVAIL)
                begin
                    any_avail_next = 1'b1;
                end
            end
            ST_VC:
            begin
                end_next = rp_clamped;
            end
            ST_E0:
            begin
                if (entries_done)
                begin
                    mk_we    = 1'b1;
                    mk_wdata = (phase_reg == PH_SEL) ? MK_NOW : MK_IN;
                end
            end
            ST_E1:
            begin
                nb_next = nb_raw[NB_W-1:0];
                if (!nb_ok)
                begin
                    e_next = e_reg + PW'(1);
                end
            end
            ST_E2:
            begin
                mk_raddr     = VAW'(nb_reg);
                prio_nb_next = prio_prod;
            end
            ST_E3:
            begin
                e_next = e_reg + PW'(1);
                if (phase_reg == PH_REM && mark_rd != MK_DONE)
                begin
                    mk_we    = 1'b1;
                    mk_waddr = VAW'(nb_reg);
                    mk_wdata = MK_CONN;
                end
            end
            ST_FA:
            begin
                mk_raddr = VAW'(v_reg);
            end
            ST_FB:
            begin
                mk_we = 1'b1;
                if (run_mode_reg)
                begin
                    mk_wdata = (mark_rd == MK_IN) ? MK_MEMBER : MK_NONE;
                end
                else if (mark_rd == MK_IN)
                begin
                    mk_wdata = MK_DONE;
                    col_we   = 1'b1;
                end
                else if (mark_rd == MK_DONE)
                begin
                    mk_wdata = MK_DONE;
                end
                else
                begin
                    mk_wdata     = MK_AVAIL;
                    any_unc_next = 1'b1;
                end
                if (last_v)
                begin
                    v_next         = '0;
                    phase_next     = PH_SEL;
                    any_avail_next = 1'b0;
                    pass_next      = pass_reg + ANS_W'(1);
                end
                else
                begin
                    v_next = vp1[NUMV_W-1:0];
                end
            end
            ST_CLEAN:
            begin
                mk_we    = 1'b1;
                mk_wdata = MK_NONE;
                v_next   = last_v ? '0 : vp1[NUMV_W-1:0];
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    from_run_next  = 1'b1;
                    answer_next    = run_mode_reg ? '0 : pass_reg;
                end
            end
            default:
            begin
            end
        endcase

        // Advance to the next vertex or sweep
        if (vertex_done)
        begin
            if (!last_v)
            begin
                v_next = vp1[NUMV_W-1:0];
            end
            else
            begin
                v_next = '0;
                if (phase_reg == PH_SEL)
                begin
                    phase_next   = any_avail_reg ? PH_REM : PH_SEL;
                    any_unc_next = 1'b0;
                end
                else
                begin
                    phase_next     = PH_SEL;
                    any_avail_next = 1'b0;
                end
            end
        end

        // Forward a write that collides with a read of the same entry
        fwd_hit_next  = mk_we && (mk_waddr == mk_raddr);
        fwd_data_next = mk_wdata;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            phase_reg        <= PH_SEL;
            clr_reg          <= '0;
            out_valid_reg    <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            num_vertices_reg <= NUMV_RESET;
            index_base_reg   <= 1'b0;
            run_mode_reg     <= 1'b0;
            seed_reg         <= SEED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_NUM_VERTICES:  num_vertices_reg <= cfg_data[NUMV_W-1:0];
                    CFG_INDEX_BASE:    index_base_reg   <= cfg_data[0];
                    CFG_RUN_MODE:      run_mode_reg     <= cfg_data[0];
                    CFG_SEED_FRACTION: seed_reg         <= cfg_data;
                    default:           seed_reg         <= seed_reg;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        e_reg         <= e_next;
        end_reg       <= end_next;
        nb_reg        <= nb_next;
        prio_v_reg    <= prio_v_next;
        prio_nb_reg   <= prio_nb_next;
        any_avail_reg <= any_avail_next;
        any_unc_reg   <= any_unc_next;
        pass_reg      <= pass_next;
        addr_reg      <= addr_next;
        answer_reg    <= answer_next;
        from_run_reg  <= from_run_next;
        fwd_data_reg  <= fwd_data_next;
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign from_run  = from_run_reg;

    // Neighbor fetch only runs inside the row range
    a_entry_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E1) |-> (e_reg < end_reg))
        else $error("neighbor fetch outside row range");

    // A result appears only from a read or a run report
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_READ
                                  || $past(state_reg) == ST_REPORT))
        else $error("result loaded from unexpected state");

    // Priority compare always follows a neighbor priority fetch
    a_compare_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E3) |-> ($past(state_reg) == ST_E2))
        else $error("neighbor compare without fetch");

endmodule
